// ===== sv/hsvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsvc_pkg;

  // Hue resolution: fraction bits of one degree.
  localparam int HUE_FRAC_BITS = 4;

  // One 60-degree sector in hue units, and the widths that follow from it.
  localparam int SECTOR_LEN = 60 * (2 ** HUE_FRAC_BITS);
  localparam int HUE_W      = $clog2(6 * SECTOR_LEN);
  localparam int T_W        = $clog2(2 * SECTOR_LEN);
  localparam int F_W        = $clog2(SECTOR_LEN + 1);

  // Channel width and full scale (255 stands for 1.0).
  localparam int CH_W       = 8;
  localparam int FULL_SCALE = 255;

  // Largest number of whole 120-degree turns a hue code can hold.
  localparam int WRAP_MAX = ((2 ** HUE_W) - 1) / (2 * SECTOR_LEN);
  // Sectors above the last one saturate to it.
  localparam int SECT_MAX = 5;

  // Numerator of the secondary channel, before and after scaling by value.
  localparam int N_W = $clog2(FULL_SCALE * SECTOR_LEN + 1);
  localparam int P_W = CH_W + N_W;

  // 255 * SECTOR_LEN = 3825 * 2^(HUE_FRAC_BITS + 2), so the power-of-two part
  // is a shift and only the odd part 3825 remains as a true divisor.
  localparam int PRE_SHIFT = HUE_FRAC_BITS + 2;
  localparam int DIVISOR   = FULL_SCALE * 15;
  localparam int Q_W       = $clog2(FULL_SCALE * DIVISOR + 1);

  // Reciprocal of the divisor; the estimate is low by at most one.
  localparam int              RECIP_SHIFT = 32;
  localparam longint unsigned RECIP_K     = (64'd1 << RECIP_SHIFT) / DIVISOR;
  localparam int              K_W         = $clog2(RECIP_K + 1);
  localparam int              M_W         = Q_W + K_W;

  // Register stages from input to output.
  localparam int STAGES = 7;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } hsvc_sector_t;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } hsvc_ld2_t;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
  } hsvc_ld3_t;

endpackage

`default_nettype wire

// ===== sv/hsvc_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hsvc_pix_in_if;
  logic                        valid;
  logic                        ready;
  logic [hsvc_pkg::HUE_W-1:0]  hue;
  logic [hsvc_pkg::CH_W-1:0]   saturation;
  logic [hsvc_pkg::CH_W-1:0]   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvc_pix_out_if;
  logic                       valid;
  logic                       ready;
  logic [hsvc_pkg::CH_W-1:0]  red;
  logic [hsvc_pkg::CH_W-1:0]  green;
  logic [hsvc_pkg::CH_W-1:0]  blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/hsvc_hue_fold.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsvc_hue_fold (
  input  wire logic                        clk,
  input  wire hsvc_pkg::hsvc_ld2_t         ld,
  input  wire logic [hsvc_pkg::HUE_W-1:0]  hue,
  output hsvc_pkg::hsvc_sector_t           sector,
  output logic [hsvc_pkg::F_W-1:0]         frac
);

  logic [hsvc_pkg::T_W-1:0]   t_c;
  logic [hsvc_pkg::HUE_W-1:0] wrap_c;
  hsvc_pkg::hsvc_sector_t     sector_c;
  logic [hsvc_pkg::T_W-1:0]   t_q;

  // Thresholds rise with k, so the last one passed wins.
  always_comb begin
    wrap_c   = hue;
    sector_c = hsvc_pkg::SEC_RED_YELLOW;
    for (int k = 1; k <= hsvc_pkg::WRAP_MAX; k++) begin
      if (hue >= hsvc_pkg::HUE_W'(k * 2 * hsvc_pkg::SECTOR_LEN)) begin
        wrap_c = hue - hsvc_pkg::HUE_W'(k * 2 * hsvc_pkg::SECTOR_LEN);
      end
    end
    for (int k = 1; k <= hsvc_pkg::SECT_MAX; k++) begin
      if (hue >= hsvc_pkg::HUE_W'(k * hsvc_pkg::SECTOR_LEN)) begin
        sector_c = hsvc_pkg::hsvc_sector_t'(3'(k));
      end
    end
    t_c = wrap_c[hsvc_pkg::T_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      t_q    <= t_c;
      sector <= sector_c;
    end
    // Distance of the hue from the nearest even sector boundary.
    if (ld.ld_b) begin
      if (t_q >= hsvc_pkg::T_W'(hsvc_pkg::SECTOR_LEN)) begin
        frac <= hsvc_pkg::F_W'(hsvc_pkg::T_W'(2 * hsvc_pkg::SECTOR_LEN) - t_q);
      end else begin
        frac <= hsvc_pkg::F_W'(t_q);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/hsvc_chroma.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsvc_chroma (
  input  wire logic                       clk,
  input  wire hsvc_pkg::hsvc_ld3_t        ld,
  input  wire logic [hsvc_pkg::CH_W-1:0]  sat,
  input  wire logic [hsvc_pkg::CH_W-1:0]  val,
  input  wire logic [hsvc_pkg::F_W-1:0]   frac,
  output logic [hsvc_pkg::Q_W-1:0]        x_num,
  output logic [hsvc_pkg::Q_W-1:0]        z_num
);

  logic [hsvc_pkg::CH_W-1:0]   sat_b;
  logic [hsvc_pkg::CH_W-1:0]   sinv_b;
  logic [hsvc_pkg::CH_W-1:0]   val_b;
  logic [2*hsvc_pkg::CH_W-1:0] zprod_b;
  logic [hsvc_pkg::CH_W-1:0]   val_c;
  logic [hsvc_pkg::N_W-1:0]    num_c;
  logic [hsvc_pkg::Q_W-1:0]    z15_c;
  logic [hsvc_pkg::P_W-1:0]    prod_w;

  assign prod_w = hsvc_pkg::P_W'(val_c) * hsvc_pkg::P_W'(num_c);

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      sat_b   <= sat;
      sinv_b  <= 8'd255 - sat;
      val_b   <= val;
      zprod_b <= (2 * hsvc_pkg::CH_W)'(val) * (2 * hsvc_pkg::CH_W)'(8'd255 - sat);
    end
    if (ld.ld_b) begin
      val_c <= val_b;
      num_c <= hsvc_pkg::N_W'(sat_b) * hsvc_pkg::N_W'(frac)
             + hsvc_pkg::N_W'(sinv_b) * hsvc_pkg::N_W'(hsvc_pkg::SECTOR_LEN);
      // Scale by 15 so that both channels share the same odd divisor.
      z15_c <= (hsvc_pkg::Q_W'(zprod_b) << 4) - hsvc_pkg::Q_W'(zprod_b);
    end
    if (ld.ld_c) begin
      x_num <= hsvc_pkg::Q_W'(prod_w >> hsvc_pkg::PRE_SHIFT);
      z_num <= z15_c;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hsvc_div3825.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsvc_div3825 (
  input  wire logic                       clk,
  input  wire hsvc_pkg::hsvc_ld2_t        ld,
  input  wire logic [hsvc_pkg::Q_W-1:0]   num,
  output logic [hsvc_pkg::CH_W-1:0]       quot
);

  logic [hsvc_pkg::M_W-1:0]  prod_w;
  logic [hsvc_pkg::Q_W-1:0]  num_q;
  logic [hsvc_pkg::CH_W-1:0] est_q;
  logic [hsvc_pkg::Q_W-1:0]  rem_w;

  assign prod_w = hsvc_pkg::M_W'(num)
                * hsvc_pkg::M_W'(hsvc_pkg::K_W'(hsvc_pkg::RECIP_K));
  assign rem_w  = num_q - hsvc_pkg::Q_W'(est_q) * hsvc_pkg::Q_W'(hsvc_pkg::DIVISOR);

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      num_q <= num;
      est_q <= prod_w[hsvc_pkg::RECIP_SHIFT +: hsvc_pkg::CH_W];
    end
    // The reciprocal estimate is never high and at most one low.
    if (ld.ld_b) begin
      if (rem_w >= hsvc_pkg::Q_W'(hsvc_pkg::DIVISOR)) begin
        quot <= est_q + 8'd1;
      end else begin
        quot <= est_q;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgb_converter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transaction payload
// pix_in    sink       hue (13 bits, 1/16 degree), saturation (8), brightness (8)
// pix_out   source     red (8), green (8), blue (8)
//
// One pixel per clock is accepted and delivered while pix_out is ready; a
// transaction passes through the seven register stages (hue fold, sector
// distance, chroma products, value scaling, two reciprocal-divider stages and
// the channel selection register).
// Every stage carries its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up and a stall on pix_out holds every
// transaction in place; pix_in is ready unless all stages are full and stalled.
// Reset (synchronous, active high) clears the valid bits only; the block keeps
// no other state.

module hsv_to_rgb_converter_core (
  input wire logic       clk,
  input wire logic       rst,
  hsvc_pix_in_if.sink    pix_in,
  hsvc_pix_out_if.source pix_out
);

  localparam int S = hsvc_pkg::STAGES;

  // Valid bit of each stage and the load enable chain that runs back from
  // the output.
  logic [S:1]   vld;
  logic [S+1:1] load;

  logic [hsvc_pkg::CH_W-1:0] sat1;
  logic [hsvc_pkg::CH_W-1:0] val1;
  logic [hsvc_pkg::CH_W-1:0] val_pipe [2:6];
  hsvc_pkg::hsvc_sector_t    sec1;
  hsvc_pkg::hsvc_sector_t    sec_pipe [2:6];

  logic [hsvc_pkg::F_W-1:0]  frac2;
  logic [hsvc_pkg::Q_W-1:0]  x_num4;
  logic [hsvc_pkg::Q_W-1:0]  z_num4;
  logic [hsvc_pkg::CH_W-1:0] x6;
  logic [hsvc_pkg::CH_W-1:0] z6;

  logic [hsvc_pkg::CH_W-1:0] red;
  logic [hsvc_pkg::CH_W-1:0] green;
  logic [hsvc_pkg::CH_W-1:0] blue;

  always_comb begin
    load[S+1] = pix_out.ready;
    for (int k = S; k >= 1; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  assign pix_in.ready  = load[1];
  assign pix_out.valid = vld[S];
  assign pix_out.red   = red;
  assign pix_out.green = green;
  assign pix_out.blue  = blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[1]) begin
        vld[1] <= pix_in.valid;
      end
      for (int k = 2; k <= S; k++) begin
        if (load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1 to stage 2: fold the hue into one 120-degree span and find the
  // sector, then the distance to the nearest even boundary.
  hsvc_hue_fold u_hue_fold (
    .clk    (clk),
    .ld     ('{ld_a: load[1], ld_b: load[2]}),
    .hue    (pix_in.hue),
    .sector (sec1),
    .frac   (frac2)
  );

  always_ff @(posedge clk) begin
    if (load[1]) begin
      sat1 <= pix_in.saturation;
      val1 <= pix_in.brightness;
    end
    if (load[2]) begin
      val_pipe[2] <= val1;
      sec_pipe[2] <= sec1;
    end
    for (int k = 3; k <= 6; k++) begin
      if (load[k]) begin
        val_pipe[k] <= val_pipe[k-1];
        sec_pipe[k] <= sec_pipe[k-1];
      end
    end
  end

  // Stages 2 to 4: numerators of the secondary and zero channels, both
  // reduced to a multiple of the common divisor 3825.
  hsvc_chroma u_chroma (
    .clk   (clk),
    .ld    ('{ld_a: load[2], ld_b: load[3], ld_c: load[4]}),
    .sat   (sat1),
    .val   (val1),
    .frac  (frac2),
    .x_num (x_num4),
    .z_num (z_num4)
  );

  // Stages 5 and 6: one reciprocal divider each for the secondary and zero channels.
  hsvc_div3825 u_div_x (
    .clk  (clk),
    .ld   ('{ld_a: load[5], ld_b: load[6]}),
    .num  (x_num4),
    .quot (x6)
  );

  hsvc_div3825 u_div_z (
    .clk  (clk),
    .ld   ('{ld_a: load[5], ld_b: load[6]}),
    .num  (z_num4),
    .quot (z6)
  );

  // Stage 7: the sector routes chroma, secondary and zero to the channels.
  // Hue beyond 360 degrees already saturated to the magenta-red sector.
  always_ff @(posedge clk) begin
    if (load[7]) begin
      case (sec_pipe[6])
        hsvc_pkg::SEC_RED_YELLOW: begin
          red <= val_pipe[6]; green <= x6;          blue <= z6;
        end
        hsvc_pkg::SEC_YELLOW_GREEN: begin
          red <= x6;          green <= val_pipe[6]; blue <= z6;
        end
        hsvc_pkg::SEC_GREEN_CYAN: begin
          red <= z6;          green <= val_pipe[6]; blue <= x6;
        end
        hsvc_pkg::SEC_CYAN_BLUE: begin
          red <= z6;          green <= x6;          blue <= val_pipe[6];
        end
        hsvc_pkg::SEC_BLUE_MAGENTA: begin
          red <= x6;          green <= z6;          blue <= val_pipe[6];
        end
        default: begin
          red <= val_pipe[6]; green <= z6;          blue <= x6;
        end
      endcase
    end
  end

  // After reset nothing is offered on the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !pix_out.valid)
    else $error("output valid right after reset");

  // With every stage full and the output stalled, no new pixel may enter.
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !pix_out.ready |-> !pix_in.ready)
    else $error("pixel accepted into a full pipeline");

  // An empty first stage always takes a pixel.
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !vld[1] |-> pix_in.ready)
    else $error("input stalled with an empty first stage");

  // The secondary channel lies between the zero channel and the chroma.
  a_channel_order: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (x6 >= z6) && (x6 <= val_pipe[6]))
    else $error("secondary channel out of order");

endmodule

`default_nettype wire
